[hw/rtl/psmt_pkg.sv]
// ----------------------------------------------------------------------------
// psmt_pkg
// Shared types and constants of the priority source multiplexer with
// timeout release.
// ----------------------------------------------------------------------------
package psmt_pkg;

    localparam int NUM_SOURCES   = 8;
    localparam int SRC_BITS      = 3;
    localparam int TICK_BITS     = 16;
    localparam int PRIO_BITS     = 8;
    localparam int VEL_BITS      = 16;
    localparam int NUM_VEL       = 6;
    localparam int DATA_BITS     = VEL_BITS * NUM_VEL;
    localparam int IN_USER_BITS  = 1 + SRC_BITS;
    localparam int OUT_USER_BITS = 3 + SRC_BITS;
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 64;
    localparam int USE_BITS      = 4;
    localparam int PRIO_FIELD    = 8;
    localparam int TIMEOUT_FIELD = 16;

    typedef logic [SRC_BITS-1:0]  src_t;
    typedef logic [TICK_BITS-1:0] tick_t;
    typedef logic [PRIO_BITS-1:0] prio_t;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_SOURCES_IN_USE    = 2'd0,
        CFG_SOURCE_PRIORITIES = 2'd1,
        CFG_TIMEOUTS_LOW      = 2'd2,
        CFG_TIMEOUTS_HIGH     = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        OP_COMMAND = 1'b0,
        OP_TICK    = 1'b1
    } op_t;

    typedef struct packed {
        logic [DATA_BITS-1:0]     data;
        logic [OUT_USER_BITS-1:0] user;
    } result_t;

endpackage

[hw/rtl/priority_source_mux_with_timeout.sv]
// ----------------------------------------------------------------------------
// priority_source_mux_with_timeout
// Command multiplexer over up to eight sources with per-source priority and
// timeout release of ownership.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one word per command or timer tick. s_tuser holds
//   op (1 = tick) and the sending source; s_tdata holds six velocity words.
//   Master stream returns one result word per input word: the forwarded
//   velocities (zero when not forwarded) and in m_tuser the forwarded flag,
//   owner-changed flag, owner-valid flag and owner index.
//   Configuration is written through cfg_we/cfg_addr/cfg_data while idle.
//   Results are registered in the result register, or the skid register
//   while the receiver stalls; one word per cycle is sustained while the
//   receiver keeps up, as arbitration and counter update are combinational.
//   A two-entry output stage (result register plus skid register) keeps
//   s_tready high while one result waits on a stalled receiver; with both
//   entries full, s_tready drops until the receiver takes a word. Reset
//   clears all tick counters, ownership, configuration and the output stage.
// ----------------------------------------------------------------------------
module priority_source_mux_with_timeout
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [psmt_pkg::CFG_ADDR_BITS-1:0]     cfg_addr,
    input  logic [psmt_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // linear_x, linear_y, linear_z, angular_x, angular_y, angular_z
    input  logic [psmt_pkg::DATA_BITS-1:0]         s_tdata,
    // op, source
    input  logic [psmt_pkg::IN_USER_BITS-1:0]      s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // out_linear_x, out_linear_y, out_linear_z, out_angular_x,
    // out_angular_y, out_angular_z
    output logic [psmt_pkg::DATA_BITS-1:0]         m_tdata,
    // forwarded, owner_changed, owner_valid, owner
    output logic [psmt_pkg::OUT_USER_BITS-1:0]     m_tuser
);
    import psmt_pkg::*;

    logic [USE_BITS-1:0]      sources_in_use_reg;
    logic [CFG_DATA_BITS-1:0] source_priorities_reg;
    logic [CFG_DATA_BITS-1:0] timeouts_low_reg;
    logic [CFG_DATA_BITS-1:0] timeouts_high_reg;

    tick_t ticks_reg  [NUM_SOURCES];
    tick_t ticks_next [NUM_SOURCES];
    src_t  owner_reg;
    src_t  owner_next;
    logic  owner_valid_reg;
    logic  owner_valid_next;

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_reg;
    result_t out_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t skid_reg;
    result_t skid_next;

    logic                          accept;
    logic                          pop;
    op_t                           op;
    src_t                          src;
    logic                          in_use;
    logic                          granted;
    logic                          changed;
    prio_t                         src_prio;
    prio_t                         owner_prio;
    tick_t                         reload;
    logic [2*CFG_DATA_BITS-1:0]    timeouts;
    result_t                       result;

    assign accept   = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;
    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.data;
    assign m_tuser  = out_reg.user;

    assign op       = op_t'(s_tuser[0]);
    assign src      = s_tuser[SRC_BITS:1];
    assign timeouts = {timeouts_high_reg, timeouts_low_reg};

    assign in_use = (sources_in_use_reg >= USE_BITS'(NUM_SOURCES))
                    || ({1'b0, src} < sources_in_use_reg);
    assign src_prio   = source_priorities_reg[PRIO_FIELD*src +: PRIO_BITS];
    assign owner_prio = source_priorities_reg[PRIO_FIELD*owner_reg +: PRIO_BITS];

    always_comb
    begin
        reload = timeouts[TIMEOUT_FIELD*src +: TICK_BITS];
        if (reload == '0)
        begin
            reload = TICK_BITS'(1);
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_SOURCES; i++)
        begin
            ticks_next[i] = ticks_reg[i];
        end
        owner_next       = owner_reg;
        owner_valid_next = owner_valid_reg;
        granted          = 1'b0;
        changed          = 1'b0;

        if (op == OP_COMMAND)
        begin
            if (in_use)
            begin
                ticks_next[src] = reload;
                if (!owner_valid_reg || owner_reg == src || src_prio > owner_prio)
                begin
                    granted = 1'b1;
                    if (!owner_valid_reg || owner_reg != src)
                    begin
                        owner_next       = src;
                        owner_valid_next = 1'b1;
                        changed          = 1'b1;
                    end
                end
            end
        end
        else
        begin
            for (int i = 0; i < NUM_SOURCES; i++)
            begin
                if (ticks_reg[i] != '0)
                begin
                    ticks_next[i] = ticks_reg[i] - TICK_BITS'(1);
                    if (ticks_reg[i] == TICK_BITS'(1) && owner_valid_reg
                        && owner_reg == SRC_BITS'(i))
                    begin
                        owner_next       = '0;
                        owner_valid_next = 1'b0;
                        changed          = 1'b1;
                    end
                end
            end
        end

        result.data = granted ? s_tdata : '0;
        result.user = {(owner_valid_next ? owner_next : src_t'(0)),
                       owner_valid_next, changed, granted};
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (accept)
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_next = 1'b1;
                out_next       = result;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_next       = result;
            end
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sources_in_use_reg    <= '0;
            source_priorities_reg <= '0;
            timeouts_low_reg      <= '0;
            timeouts_high_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_addr))
                CFG_SOURCES_IN_USE:    sources_in_use_reg    <= cfg_data[USE_BITS-1:0];
                CFG_SOURCE_PRIORITIES: source_priorities_reg <= cfg_data;
                CFG_TIMEOUTS_LOW:      timeouts_low_reg      <= cfg_data;
                CFG_TIMEOUTS_HIGH:     timeouts_high_reg     <= cfg_data;
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SOURCES; i++)
            begin
                ticks_reg[i] <= '0;
            end
            owner_reg       <= '0;
            owner_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            for (int i = 0; i < NUM_SOURCES; i++)
            begin
                ticks_reg[i] <= ticks_next[i];
            end
            owner_reg       <= owner_next;
            owner_valid_reg <= owner_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule
